// File: hdl/sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue.
// Used by the top level; expects clk and rst in scope.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned VALUE_BITS    = 16;
  localparam int unsigned PRIORITY_BITS = 8;
  localparam int unsigned OCC_BITS      = $clog2(CAPACITY + 1);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                     opcode;
    logic [VALUE_BITS-1:0]    item_value;
    logic [PRIORITY_BITS-1:0] item_priority;
  } spq_cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [VALUE_BITS-1:0]    head_value;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [OCC_BITS-1:0]      occupancy;
  } spq_rsp_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
  } spq_entry_t;

  // Broadcast to every cell in the operation cycle.
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t item;
  } spq_ctl_t;

endpackage

// File: hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the new one,
// and shifts toward the tail on insert or toward the head on removal. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_ctl_t   ctl,
  input  logic               occupied,
  input  logic               left_ge,
  input  spq_pkg::spq_entry_t left_entry,
  input  spq_pkg::spq_entry_t right_entry,
  output logic               ge,
  output spq_pkg::spq_entry_t entry
);
  import spq_pkg::*;

  // Held entry stays ahead of the new one on equal priority.
  assign ge = occupied && (entry.prio >= ctl.item.prio);

  always_ff @(posedge clk) begin
    if (ctl.enq && !ge) begin
      if (left_ge) begin
        entry <= ctl.item;
      end else begin
        entry <= left_entry;
      end
    end else if (ctl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

// File: hdl/sorted_priority_queue.sv
// Sorted priority queue: a chain of compare-and-shift cells plus command and
// response control. Uses spq_pkg, spq_cell and sorted_priority_queue_macros.svh.
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

// Each operation runs as two steps: the edge that accepts start registers the
// command and raises busy; the next edge lets every cell compare its entry with
// the new priority and shift one place in parallel, and the result appears on
// rsp with done high for exactly that following cycle. A new start is taken
// while done is shown, but never while busy is high. The
// receiver cannot stall: rsp is valid only in the cycle that done is high.
// An enqueue into a full queue reports ST_FULL and leaves the contents alone;
// a dequeue from an empty queue reports ST_EMPTY. Entries of equal priority
// leave in arrival order.
module sorted_priority_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  spq_pkg::spq_cmd_t cmd,
  output logic             busy,
  output logic             done,
  output spq_pkg::spq_rsp_t rsp
);
  import spq_pkg::*;

  logic                pend;
  spq_cmd_t            cmd_q;
  logic [OCC_BITS-1:0] count;
  logic [OCC_BITS-1:0] count_next;
  spq_ctl_t            ctl;
  spq_rsp_t            rsp_next;
  logic                is_full;
  logic                is_empty;

  spq_entry_t          entries [CAPACITY];
  logic [CAPACITY-1:0] ge_vec;

  assign busy     = pend;
  assign is_full  = (count == OCC_BITS'(CAPACITY));
  assign is_empty = (count == '0);

  always_comb begin
    ctl.enq           = pend && (cmd_q.opcode == OP_ENQ) && !is_full;
    ctl.deq           = pend && (cmd_q.opcode == OP_DEQ) && !is_empty;
    ctl.item.value    = cmd_q.item_value;
    ctl.item.prio     = cmd_q.item_priority;

    count_next        = count;
    rsp_next.status   = ST_OK;
    rsp_next.head_value    = '0;
    rsp_next.head_priority = '0;
    if (cmd_q.opcode == OP_ENQ) begin
      if (is_full) begin
        rsp_next.status = ST_FULL;
      end else begin
        count_next = count + OCC_BITS'(1);
      end
    end else begin
      if (is_empty) begin
        rsp_next.status = ST_EMPTY;
      end else begin
        count_next             = count - OCC_BITS'(1);
        rsp_next.head_value    = entries[0].value;
        rsp_next.head_priority = entries[0].prio;
      end
    end
    rsp_next.occupancy = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= pend;
      if (pend) begin
        pend  <= 1'b0;
        count <= count_next;
      end else if (start) begin
        pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !pend) begin
      cmd_q <= cmd;
    end
    if (pend) begin
      rsp <= rsp_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       occ;
    logic       lge;
    spq_entry_t lent;
    spq_entry_t rent;

    assign occ = (count > OCC_BITS'(i));

    if (i == 0) begin : g_head
      // Head slot has nothing ahead of it.
      assign lge  = 1'b1;
      assign lent = '0;
    end else begin : g_body
      assign lge  = ge_vec[i-1];
      assign lent = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rent = '0;
    end else begin : g_mid
      assign rent = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .left_ge     (lge),
      .left_entry  (lent),
      .right_entry (rent),
      .ge          (ge_vec[i]),
      .entry       (entries[i])
    );
  end

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= OCC_BITS'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted beat not held")
  `SPQ_ASSERT_NEXT(a_busy_done, busy, done && !busy, "busy beat gave no result")
  `SPQ_ASSERT_NOW(a_head_sorted, count >= OCC_BITS'(2), entries[0].prio >= entries[1].prio, "head out of order")

endmodule

// File: sim/spq_order_checker.sv
// Checker for the sorted priority queue: watches command and result beats,
// keeps its own ordered store of entries and compares every result field.
// Depends on spq_pkg for the beat types, codes and sizes.
`timescale 1ns / 1ps

module spq_order_checker
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  spq_cmd_t cmd,
  input  logic     done,
  input  spq_rsp_t rsp,
  output int       fail_count,
  output int       outstanding
);

  logic [VALUE_BITS-1:0]    held_value [CAPACITY];
  logic [PRIORITY_BITS-1:0] held_prio  [CAPACITY];
  int unsigned              held_count = 0;
  spq_rsp_t                 rsp_due_q [$];
  int                       err_cnt = 0;

  // Apply one command to the held store and return the result it must produce.
  function automatic spq_rsp_t serve_command(spq_cmd_t c);
    spq_rsp_t    r;
    int unsigned slot;
    r = '0;
    if (c.opcode == OP_ENQ) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // Go past every entry of greater or equal priority to keep arrival order.
        slot = 0;
        while (slot < held_count && held_prio[slot] >= c.item_priority) slot++;
        for (int unsigned i = held_count; i > slot; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[slot] = c.item_value;
        held_prio[slot]  = c.item_priority;
        held_count++;
        r.status = ST_OK;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status        = ST_OK;
      r.head_value    = held_value[0];
      r.head_priority = held_prio[0];
      for (int unsigned i = 1; i < held_count; i++) begin
        held_value[i-1] = held_value[i];
        held_prio[i-1]  = held_prio[i];
      end
      held_count--;
    end
    r.occupancy = OCC_BITS'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    spq_rsp_t want;
    if (!rst) begin
      // Retire the result beat first; a command taken at the same edge queues behind it.
      if (done) begin
        if (rsp_due_q.size() == 0) begin
          $error("result beat with no command waiting");
          err_cnt++;
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            err_cnt++;
          end
          if (rsp.head_value !== want.head_value) begin
            $error("head_value: expected %0h, got %0h", want.head_value, rsp.head_value);
            err_cnt++;
          end
          if (rsp.head_priority !== want.head_priority) begin
            $error("head_priority: expected %0h, got %0h",
                   want.head_priority, rsp.head_priority);
            err_cnt++;
          end
          if (rsp.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, rsp.occupancy);
            err_cnt++;
          end
        end
      end
      if (start && !busy) rsp_due_q.push_back(serve_command(cmd));
    end
    fail_count  <= err_cnt;
    outstanding <= rsp_due_q.size();
  end

endmodule

// File: sim/sorted_priority_queue_tb.sv
// Top of the sorted priority queue testbench: clock, reset and command stimulus.
// Depends on spq_pkg, sorted_priority_queue and spq_order_checker.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  logic     clk;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  spq_cmd_t cmd   = '0;
  logic     busy;
  logic     done;
  spq_rsp_t rsp;
  int       fail_count;
  int       outstanding;
  int       idle_pct = 8;

  sorted_priority_queue uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  spq_order_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold one command beat until taken, then idle at random with noise on cmd.
  task automatic issue(input logic op, input logic [VALUE_BITS-1:0] val,
                       input logic [PRIORITY_BITS-1:0] prio);
    spq_cmd_t    c;
    logic [31:0] noise;
    c.opcode        = op;
    c.item_value    = val;
    c.item_priority = prio;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    while ($urandom_range(0, 99) < idle_pct) begin
      noise = $urandom;
      start <= 1'b0;
      cmd   <= noise[$bits(spq_cmd_t)-1:0];
      @(posedge clk);
    end
  endtask

  initial begin
    int                       burst_left;
    int                       enq_pct;
    int                       sel;
    logic [PRIORITY_BITS-1:0] prio;
    burst_left = 0;
    enq_pct    = 50;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dequeue, extremes, ties at head, middle and tail, full drop.
    issue(OP_DEQ, 16'h1234, 8'h55);
    issue(OP_ENQ, 16'h0000, 8'h00);
    issue(OP_ENQ, 16'hFFFF, 8'hFF);
    issue(OP_ENQ, 16'h0001, 8'h80);
    issue(OP_ENQ, 16'h0002, 8'h80);
    issue(OP_ENQ, 16'h0003, 8'h80);
    issue(OP_ENQ, 16'h0004, 8'hFF);
    issue(OP_ENQ, 16'h0005, 8'h00);
    for (int i = 0; i < 9; i++) issue(OP_ENQ, VALUE_BITS'(32'hA500 | i), 8'(i * 29));
    issue(OP_ENQ, 16'hFFFF, 8'hFF);
    repeat (7) issue(OP_DEQ, VALUE_BITS'($urandom), PRIORITY_BITS'($urandom));

    // Random bursts lean toward filling or draining so both full and empty recur.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 8 : (ph == 1) ? 88 : 0;
      for (int n = 0; n < 567; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(8, 40);
          case ($urandom_range(0, 2))
            0:       enq_pct = 15;
            1:       enq_pct = 50;
            default: enq_pct = 85;
          endcase
        end
        burst_left--;
        sel = $urandom_range(0, 9);
        if (sel < 4)      prio = PRIORITY_BITS'($urandom_range(0, 3));
        else if (sel < 5) prio = $urandom_range(0, 1) ? '1 : '0;
        else              prio = PRIORITY_BITS'($urandom);
        issue(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ,
              VALUE_BITS'($urandom), prio);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
